// File: rtl/crtc_pkg.sv
// Shared types, register indexes and helpers for the CMOS/RTC register device.
package crtc_pkg;

	localparam int STORE_BYTES_DEF = 128;
	localparam int IDX_W = 7;

	typedef enum logic [1:0] {
		OP_IO_READ  = 2'd0,
		OP_IO_WRITE = 2'd1,
		OP_SEC_TICK = 2'd2,
		OP_PER_TICK = 2'd3
	} crtc_op_t;

	localparam logic PORT_ADDR = 1'b0;
	localparam logic PORT_DATA = 1'b1;

	localparam logic [2:0] SIZE_BYTE = 3'd1;

	localparam logic [IDX_W-1:0] IDX_SEC     = 7'h00;
	localparam logic [IDX_W-1:0] IDX_ALM_SEC = 7'h01;
	localparam logic [IDX_W-1:0] IDX_MIN     = 7'h02;
	localparam logic [IDX_W-1:0] IDX_ALM_MIN = 7'h03;
	localparam logic [IDX_W-1:0] IDX_HR      = 7'h04;
	localparam logic [IDX_W-1:0] IDX_ALM_HR  = 7'h05;
	localparam logic [IDX_W-1:0] REG_A       = 7'h0A;
	localparam logic [IDX_W-1:0] REG_B       = 7'h0B;
	localparam logic [IDX_W-1:0] REG_C       = 7'h0C;
	localparam logic [IDX_W-1:0] REG_D       = 7'h0D;

	localparam logic [7:0] RST_A = 8'h26;
	localparam logic [7:0] RST_B = 8'h02;
	localparam logic [7:0] RST_C = 8'h00;
	localparam logic [7:0] RST_D = 8'h80;

	localparam logic [7:0] BAD_READ   = 8'hFF;
	localparam logic [7:0] MASK_IDX   = 8'h7F;
	localparam logic [7:0] MASK_A     = 8'h7F;
	localparam logic [7:0] MASK_B     = 8'hF7;
	localparam logic [7:0] MASK_B_SET = 8'hEF;
	localparam logic [7:0] IRQ_UPDATE = 8'h90;
	localparam logic [7:0] IRQ_ALARM  = 8'hA0;
	localparam logic [7:0] IRQ_PERIOD = 8'hC0;

	// write request from the control logic to the general store
	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] addr;
		logic [7:0]       data;
	} crtc_wr_t;

	// tens by x*13 >> 7, exact for 0..63
	function automatic logic [7:0] to_bcd(input logic [5:0] x);
		logic [9:0] prod;
		logic [3:0] tens;
		logic [5:0] units;
		prod  = 10'(x) * 10'd13;
		tens  = 4'(prod[9:7]);
		units = x - 6'(tens) * 6'd10;
		return {tens, units[3:0]};
	endfunction

	function automatic logic alarm_hit(input logic [7:0] now, input logic [7:0] alm);
		return (alm[7:6] == 2'b11) || (now == alm);
	endfunction

endpackage

// File: rtl/cmos_rtc_register_device.sv
// Top level of the CMOS/RTC register device: item register, register logic, result register.
//
//  channel | signals                                         | dir | handshake
//  --------+-------------------------------------------------+-----+------------------
//  in      | operation port_select access_size write_data    | in  | in_valid/in_ready
//          | tick_seconds tick_minutes tick_hours            |     |
//  out     | read_data irq_request periodic_running          | out | out_valid/out_ready
//          | periodic_rate                                   |     |
//
// One item per cycle while no result is stalled; each item waits in the item register and
// its result is then written to the result register.
// The store read is issued on the accept edge, one port of the general store.
// Reset sets the device state, valid flags and store valid bits at once; no clearing pass.
// A stalled result holds the item register, and in_ready drops only then.
module cmos_rtc_register_device #(
	parameter int STORE_BYTES = crtc_pkg::STORE_BYTES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] operation,
	input  logic       port_select,
	input  logic [2:0] access_size,
	input  logic [7:0] write_data,
	input  logic [5:0] tick_seconds,
	input  logic [5:0] tick_minutes,
	input  logic [4:0] tick_hours,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] read_data,
	output logic       irq_request,
	output logic       periodic_running,
	output logic [3:0] periodic_rate
);

	localparam logic [7:0] STORE_LIMIT = 8'(STORE_BYTES);

	// item register
	logic                        s1_valid_q;
	crtc_pkg::crtc_op_t          op_s1;
	logic                        port_s1;
	logic [2:0]                  size_s1;
	logic [7:0]                  wdata_s1;
	logic [5:0]                  sec_s1;
	logic [5:0]                  min_s1;
	logic [4:0]                  hr_s1;

	// device state
	logic [crtc_pkg::IDX_W-1:0]  addr_q;
	logic [3:0]                  rate_q;
	logic [7:0]                  sec_q, alm_sec_q, min_q, alm_min_q, hr_q, alm_hr_q;
	logic [7:0]                  a_q, b_q, c_q, d_q;

	// result register
	logic                        out_valid_q;
	logic [7:0]                  read_data_q;
	logic                        irq_q;
	logic                        running_q;
	logic [3:0]                  rate_out_q;

	logic                        accept;
	logic                        advance;
	logic                        commit;
	logic                        in_store;
	logic [crtc_pkg::IDX_W-1:0]  rd_addr;
	logic [7:0]                  store_rdata;
	crtc_pkg::crtc_wr_t          wr;

	logic [crtc_pkg::IDX_W-1:0]  addr_n;
	logic [3:0]                  rate_n;
	logic [7:0]                  sec_n, alm_sec_n, min_n, alm_min_n, hr_n, alm_hr_n;
	logic [7:0]                  a_n, b_n, c_n;
	logic [7:0]                  rd_n;
	logic                        irq_n;
	logic [7:0]                  cur_byte;
	logic [7:0]                  bdata;

	assign advance  = !out_valid_q || out_ready;
	assign commit   = s1_valid_q && advance;
	assign in_ready = !s1_valid_q || advance;
	assign accept   = in_valid && in_ready;
	assign in_store = {1'b0, addr_q} < STORE_LIMIT;

	// the index the next item sees: a committing address write moves it
	assign rd_addr = (commit && op_s1 == crtc_pkg::OP_IO_WRITE
		&& size_s1 == crtc_pkg::SIZE_BYTE && port_s1 == crtc_pkg::PORT_ADDR)
		? 7'(wdata_s1 & crtc_pkg::MASK_IDX) : addr_q;

	crtc_store #(
		.STORE_BYTES(STORE_BYTES)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (wr),
		.rd_en   (accept),
		.rd_addr (rd_addr),
		.rd_data (store_rdata)
	);

	always_comb begin
		case (addr_q)
			crtc_pkg::IDX_SEC:     cur_byte = sec_q;
			crtc_pkg::IDX_ALM_SEC: cur_byte = alm_sec_q;
			crtc_pkg::IDX_MIN:     cur_byte = min_q;
			crtc_pkg::IDX_ALM_MIN: cur_byte = alm_min_q;
			crtc_pkg::IDX_HR:      cur_byte = hr_q;
			crtc_pkg::IDX_ALM_HR:  cur_byte = alm_hr_q;
			crtc_pkg::REG_A:       cur_byte = a_q;
			crtc_pkg::REG_B:       cur_byte = b_q;
			crtc_pkg::REG_C:       cur_byte = c_q;
			crtc_pkg::REG_D:       cur_byte = d_q;
			default:               cur_byte = store_rdata;
		endcase
	end

	always_comb begin
		addr_n    = addr_q;
		rate_n    = rate_q;
		sec_n     = sec_q;
		alm_sec_n = alm_sec_q;
		min_n     = min_q;
		alm_min_n = alm_min_q;
		hr_n      = hr_q;
		alm_hr_n  = alm_hr_q;
		a_n       = a_q;
		b_n       = b_q;
		c_n       = c_q;
		rd_n      = 8'h00;
		irq_n     = 1'b0;
		wr        = '0;
		wr.addr   = addr_q;
		wr.data   = wdata_s1;
		bdata     = wdata_s1 & crtc_pkg::MASK_B;
		if (bdata[7]) begin
			bdata = bdata & crtc_pkg::MASK_B_SET;
		end
		case (op_s1)
			crtc_pkg::OP_IO_READ: begin
				rd_n = crtc_pkg::BAD_READ;
				if (size_s1 == crtc_pkg::SIZE_BYTE && port_s1 == crtc_pkg::PORT_DATA
					&& in_store) begin
					rd_n = cur_byte;
					if (addr_q == crtc_pkg::REG_C) begin
						c_n = 8'h00;
					end
				end
			end
			crtc_pkg::OP_IO_WRITE: begin
				if (size_s1 == crtc_pkg::SIZE_BYTE) begin
					if (port_s1 == crtc_pkg::PORT_ADDR) begin
						addr_n = 7'(wdata_s1 & crtc_pkg::MASK_IDX);
					end else if (in_store) begin
						case (addr_q)
							crtc_pkg::IDX_SEC:     sec_n = wdata_s1;
							crtc_pkg::IDX_ALM_SEC: alm_sec_n = wdata_s1;
							crtc_pkg::IDX_MIN:     min_n = wdata_s1;
							crtc_pkg::IDX_ALM_MIN: alm_min_n = wdata_s1;
							crtc_pkg::IDX_HR:      hr_n = wdata_s1;
							crtc_pkg::IDX_ALM_HR:  alm_hr_n = wdata_s1;
							crtc_pkg::REG_A:       a_n = wdata_s1 & crtc_pkg::MASK_A;
							crtc_pkg::REG_B: begin
								// latch the rate on a rising periodic enable
								if (!b_q[6] && bdata[6]) begin
									rate_n = a_q[3:0];
								end
								b_n = bdata;
							end
							crtc_pkg::REG_C: ;
							crtc_pkg::REG_D: ;
							default:               wr.en = 1'b1;
						endcase
					end
				end
			end
			crtc_pkg::OP_SEC_TICK: begin
				if (!b_q[7]) begin
					sec_n = crtc_pkg::to_bcd(sec_s1);
					min_n = crtc_pkg::to_bcd(min_s1);
					hr_n  = crtc_pkg::to_bcd({1'b0, hr_s1});
					if (b_q[4]) begin
						c_n   = c_n | crtc_pkg::IRQ_UPDATE;
						irq_n = 1'b1;
					end
					if (b_q[5] && crtc_pkg::alarm_hit(sec_n, alm_sec_q)
						&& crtc_pkg::alarm_hit(min_n, alm_min_q)
						&& crtc_pkg::alarm_hit(hr_n, alm_hr_q)) begin
						c_n   = c_n | crtc_pkg::IRQ_ALARM;
						irq_n = 1'b1;
					end
				end
			end
			crtc_pkg::OP_PER_TICK: begin
				if (b_q[6]) begin
					c_n   = c_n | crtc_pkg::IRQ_PERIOD;
					irq_n = 1'b1;
				end
			end
			default: ;
		endcase
		wr.en = wr.en && commit;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1    <= crtc_pkg::crtc_op_t'(operation);
			port_s1  <= port_select;
			size_s1  <= access_size;
			wdata_s1 <= write_data;
			sec_s1   <= tick_seconds;
			min_s1   <= tick_minutes;
			hr_s1    <= tick_hours;
		end
		if (commit) begin
			read_data_q <= rd_n;
			irq_q       <= irq_n;
			running_q   <= b_n[6] && (rate_n != 4'd0);
			rate_out_q  <= rate_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
			addr_q      <= '0;
			rate_q      <= '0;
			sec_q       <= 8'h00;
			alm_sec_q   <= 8'h00;
			min_q       <= 8'h00;
			alm_min_q   <= 8'h00;
			hr_q        <= 8'h00;
			alm_hr_q    <= 8'h00;
			a_q         <= crtc_pkg::RST_A;
			b_q         <= crtc_pkg::RST_B;
			c_q         <= crtc_pkg::RST_C;
			d_q         <= crtc_pkg::RST_D;
		end else begin
			if (accept) begin
				s1_valid_q <= 1'b1;
			end else if (commit) begin
				s1_valid_q <= 1'b0;
			end
			if (commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (commit) begin
				addr_q    <= addr_n;
				rate_q    <= rate_n;
				sec_q     <= sec_n;
				alm_sec_q <= alm_sec_n;
				min_q     <= min_n;
				alm_min_q <= alm_min_n;
				hr_q      <= hr_n;
				alm_hr_q  <= alm_hr_n;
				a_q       <= a_n;
				b_q       <= b_n;
				c_q       <= c_n;
			end
		end
	end

	assign out_valid        = out_valid_q;
	assign read_data        = read_data_q;
	assign irq_request      = irq_q;
	assign periodic_running = running_q;
	assign periodic_rate    = rate_out_q;

endmodule

// File: rtl/crtc_store.sv
// General CMOS byte store: one write and one registered read port, valid bits for reset.
module crtc_store #(
	parameter int STORE_BYTES = crtc_pkg::STORE_BYTES_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  crtc_pkg::crtc_wr_t           wr,
	input  logic                         rd_en,
	input  logic [crtc_pkg::IDX_W-1:0]   rd_addr,
	output logic [7:0]                   rd_data
);

	localparam int AW = $clog2(STORE_BYTES);

	logic [7:0]             mem [STORE_BYTES];
	logic [STORE_BYTES-1:0] vld_q;
	logic [7:0]             mem_q;
	logic [7:0]             fwd_data_q;
	logic                   fwd_q;
	logic                   rvld_q;
	logic [AW-1:0]          wa;
	logic [AW-1:0]          ra;

	assign wa = wr.addr[AW-1:0];
	assign ra = rd_addr[AW-1:0];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wa] <= wr.data;
		end
		if (rd_en) begin
			mem_q      <= mem[ra];
			fwd_data_q <= wr.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			fwd_q  <= 1'b0;
			rvld_q <= 1'b0;
		end else begin
			if (wr.en) begin
				vld_q[wa] <= 1'b1;
			end
			if (rd_en) begin
				// bypass a write landing on the same edge
				fwd_q  <= wr.en && (wa == ra);
				rvld_q <= vld_q[ra];
			end
		end
	end

	assign rd_data = fwd_q ? fwd_data_q : (rvld_q ? mem_q : 8'h00);

endmodule

// File: rtl/crtc_checker.sv
// Port-level checks for the CMOS/RTC register device, bound to the top level.
module crtc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic       periodic_running,
	input logic [3:0] periodic_rate
);

	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// input stalls only behind a waiting result
	a_stall_source: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled without an output stall");

	// a running periodic timer never shows rate zero
	a_running_rate: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && periodic_running |-> periodic_rate != 4'd0)
		else $error("periodic running with zero rate");

	// a fresh result always follows an accepted item
	a_result_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2))
		else $error("result without a matching item");

endmodule

bind cmos_rtc_register_device crtc_checker u_crtc_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.in_valid         (in_valid),
	.in_ready         (in_ready),
	.out_valid        (out_valid),
	.out_ready        (out_ready),
	.periodic_running (periodic_running),
	.periodic_rate    (periodic_rate)
);
